FILE: hw/rtl/bsfe_pkg.sv
// ============================================================================
// bsfe_pkg
// shared types and constants for the byte stuffing frame encoder
// ============================================================================
package bsfe_pkg;

    localparam logic [7:0] ESC_BYTE = 8'h1a;
    localparam logic [7:0] END_BYTE = 8'h1b;
    localparam logic [7:0] ESC_XOR  = 8'h20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // one accepted payload byte as seen by the back end
    typedef struct packed {
        logic [7:0] payload;
        logic       last;
        logic [7:0] checksum;   // sum including this byte, used only when last
    } bsfe_entry_t;

    typedef enum logic [1:0] {
        PH_BYTE,
        PH_SUM,
        PH_END
    } bsfe_phase_t;

    function automatic logic is_special(input logic [7:0] b);
        return (b == ESC_BYTE) || (b == END_BYTE);
    endfunction

endpackage

FILE: hw/rtl/bsfe_front.sv
// ============================================================================
// bsfe_front
// accepts payload bytes and keeps the running packet checksum
// ============================================================================
module bsfe_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // payload_byte
    input  logic                 s_tlast,    // packet_last
    input  logic                 q_full,
    output logic                 q_push,
    output bsfe_pkg::bsfe_entry_t q_entry
);

    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic [7:0] sum_with_byte;

    assign s_tready      = !q_full;
    assign q_push        = s_tvalid && !q_full;
    assign sum_with_byte = running_sum_reg + s_tdata;

    assign q_entry.payload  = s_tdata;
    assign q_entry.last     = s_tlast;
    assign q_entry.checksum = sum_with_byte;

    always_comb
    begin
        running_sum_next = running_sum_reg;
        if (q_push)
        begin
            running_sum_next = s_tlast ? 8'h00 : sum_with_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= 8'h00;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

FILE: hw/rtl/bsfe_queue.sv
// ============================================================================
// bsfe_queue
// short fifo between the front and back ends
// ============================================================================
module bsfe_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bsfe_pkg::bsfe_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output bsfe_pkg::bsfe_entry_t head_entry
);

    bsfe_pkg::bsfe_entry_t         mem_reg [bsfe_pkg::QUEUE_DEPTH];
    logic [bsfe_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [bsfe_pkg::QUEUE_AW-1:0] wr_ptr_next;
    logic [bsfe_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [bsfe_pkg::QUEUE_AW-1:0] rd_ptr_next;
    logic [bsfe_pkg::QUEUE_CW-1:0] count_reg;
    logic [bsfe_pkg::QUEUE_CW-1:0] count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (count_reg == bsfe_pkg::QUEUE_CW'(bsfe_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/bsfe_back.sv
// ============================================================================
// bsfe_back
// expands queued bytes into escaped line bytes, checksum and end marker
// ============================================================================
module bsfe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  bsfe_pkg::bsfe_entry_t head_entry,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // line_byte
    output logic                  m_tlast    // frame_end
);

    bsfe_pkg::bsfe_phase_t phase_reg;
    bsfe_pkg::bsfe_phase_t phase_next;
    logic                  esc_half_reg;    // escape byte sent, xored byte pending
    logic                  esc_half_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            out_data_reg;
    logic [7:0]            out_data_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic                  load;
    logic [7:0]            cur_byte;
    logic                  cur_special;

    assign load        = head_valid && (!out_valid_reg || m_tready);
    assign cur_byte    = (phase_reg == bsfe_pkg::PH_SUM) ? head_entry.checksum
                                                         : head_entry.payload;
    assign cur_special = bsfe_pkg::is_special(cur_byte);

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        esc_half_next = esc_half_reg;
        if (load)
        begin
            case (phase_reg)
                bsfe_pkg::PH_END:
                begin
                    phase_next = bsfe_pkg::PH_BYTE;
                end
                bsfe_pkg::PH_BYTE,
                bsfe_pkg::PH_SUM:
                begin
                    if (cur_special && !esc_half_reg)
                    begin
                        esc_half_next = 1'b1;
                    end
                    else
                    begin
                        esc_half_next = 1'b0;
                        if (phase_reg == bsfe_pkg::PH_SUM)
                        begin
                            phase_next = bsfe_pkg::PH_END;
                        end
                        else if (head_entry.last)
                        begin
                            phase_next = bsfe_pkg::PH_SUM;
                        end
                    end
                end
                default:
                begin
                    phase_next = bsfe_pkg::PH_BYTE;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            case (phase_reg)
                bsfe_pkg::PH_END:
                begin
                    out_data_next = bsfe_pkg::END_BYTE;
                    out_last_next = 1'b1;
                    pop           = 1'b1;
                end
                bsfe_pkg::PH_BYTE,
                bsfe_pkg::PH_SUM:
                begin
                    out_last_next = 1'b0;
                    if (cur_special && !esc_half_reg)
                    begin
                        out_data_next = bsfe_pkg::ESC_BYTE;
                    end
                    else
                    begin
                        out_data_next = esc_half_reg ? (cur_byte ^ bsfe_pkg::ESC_XOR)
                                                     : cur_byte;
                        pop = (phase_reg == bsfe_pkg::PH_BYTE) && !head_entry.last;
                    end
                end
                default:
                begin
                    out_data_next = cur_byte;
                    out_last_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= bsfe_pkg::PH_BYTE;
            esc_half_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            esc_half_reg  <= esc_half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/byte_stuffing_frame_encoder_top.sv
// ============================================================================
// byte_stuffing_frame_encoder_top
// byte stuffing frame encoder with 8-bit additive checksum and end marker
// ----------------------------------------------------------------------------
//   channel | direction | tdata         | tlast
//   s_*     | in        | payload_byte  | packet_last
//   m_*     | out       | line_byte     | frame_end
//
// each accepted byte yields 1 or 2 line bytes, a last byte 3 to 5; the output
// register sends one line byte per cycle while m_tready is high.
// a 4-entry queue between front and back lets input be taken while output
// stalls; s_tready drops only when the queue is full.
// asynchronous active-low reset clears checksum, queue and output state.
// ============================================================================
module byte_stuffing_frame_encoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] payload_byte
    input  logic       s_tlast,   // packet_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] line_byte
    output logic       m_tlast    // frame_end
);

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_head_valid;
    bsfe_pkg::bsfe_entry_t q_push_entry;
    bsfe_pkg::bsfe_entry_t q_head_entry;

    bsfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    bsfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    bsfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
